@@ rtl/sha_pkg.sv @@
// sha_pkg: shared types, constants and round functions for the sha-256 stream hasher
// used by sha_ctrl, sha_dp and sha256_stream_hasher_unit
`timescale 1ns / 1ps
package sha_pkg;

  localparam int unsigned BlockWords = 16;
  localparam int unsigned CountWidth = 61;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_FOLD,
    ST_PAD,
    ST_EMIT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic take_byte;   // pack incoming byte
    logic start;       // load working vars from chain
    logic round;       // run one round
    logic fold;        // add working vars into chain
    logic pad_fill;    // write padding into block
    logic pad_len;     // write length words too
    logic zero_block;  // clear block and write length words for second pad block
    logic emit_shift;  // advance digest output
    logic finish;      // restore initial hash, clear count
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic       block_full;  // next byte fills the block
    logic       last_round;
    logic       pad_two;     // padding needs two blocks
  } dp_stat_t;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] round_k(input logic [5:0] t);
    logic [31:0] k [64];
    k = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };
    round_k = k[t];
  endfunction

  function automatic logic [31:0] initial_hash(input logic [2:0] i);
    logic [31:0] h [8];
    h = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
          32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
    initial_hash = h[i];
  endfunction

endpackage

@@ rtl/sha256_stream_hasher_unit.sv @@
// sha256_stream_hasher_unit: top level, joins sha_ctrl and sha_dp
// depends on sha_pkg, sha_ctrl, sha_dp
//
// channel  direction  handshake              payload
// in       sink       in_valid / in_stall     data_byte, byte_present, end_of_message
// out      source     out_valid / out_stall   digest_word, word_index, last_word
//
// bytes are taken one per cycle while idle; the 64th byte of a block starts 64 rounds and a fold
// end of message adds a pad step and compression of one or two pad blocks, then 8 words
// rounds run one per cycle through a single round unit
// synchronous reset restores the initial hash and clears the count
// input stalls during padding, compression and digest output
`timescale 1ns / 1ps
module sha256_stream_hasher_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        byte_present,
  input  logic        end_of_message,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word
);

  sha_pkg::dp_cmd_t  cmd;
  sha_pkg::dp_stat_t stat;

  sha_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .byte_present, .end_of_message,
    .out_stall, .out_valid, .word_index, .stat, .cmd
  );

  sha_dp u_dp (
    .clk, .rst, .cmd, .data_byte, .stat, .digest_word
  );

  assign last_word = (word_index == 3'd7);

endmodule

@@ rtl/sha_dp.sv @@
// sha_dp: byte packing, block and schedule registers, round logic, chain value, digest output
// depends on sha_pkg
`timescale 1ns / 1ps
module sha_dp (
  input  logic                    clk,
  input  logic                    rst,
  input  sha_pkg::dp_cmd_t        cmd,
  input  logic [7:0]              data_byte,
  output sha_pkg::dp_stat_t       stat,
  output logic [31:0]             digest_word
);

  logic [31:0] blk [16];
  logic [31:0] chain [8];
  logic [31:0] wv [8];
  logic [sha_pkg::CountWidth-1:0] byte_count;
  logic [5:0]  rnd;
  logic [5:0]  pos;
  logic [31:0] w, t1, t2, s0, s1;
  logic [63:0] bits;

  assign pos  = byte_count[5:0];
  assign bits = {byte_count, 3'b000};

  // schedule: window of 16 rolled in place, word t sits at blk[0]
  always_comb begin
    s0 = sha_pkg::rotr(blk[1], 7) ^ sha_pkg::rotr(blk[1], 18) ^ (blk[1] >> 3);
    s1 = sha_pkg::rotr(blk[14], 17) ^ sha_pkg::rotr(blk[14], 19) ^ (blk[14] >> 10);
    w  = blk[0];
    t1 = wv[7] + (sha_pkg::rotr(wv[4], 6) ^ sha_pkg::rotr(wv[4], 11) ^ sha_pkg::rotr(wv[4], 25))
       + ((wv[4] & wv[5]) ^ (~wv[4] & wv[6])) + sha_pkg::round_k(rnd) + w;
    t2 = (sha_pkg::rotr(wv[0], 2) ^ sha_pkg::rotr(wv[0], 13) ^ sha_pkg::rotr(wv[0], 22))
       + ((wv[0] & wv[1]) ^ (wv[0] & wv[2]) ^ (wv[1] & wv[2]));
  end

  assign stat.block_full = (pos == 6'd63);
  assign stat.last_round = (rnd == 6'd63);
  assign stat.pad_two    = (pos >= 6'd56);
  assign digest_word     = chain[0];

  always_ff @(posedge clk) begin
    if (cmd.take_byte) begin
      blk[pos[5:2]] <= (pos[1:0] == 2'd0) ? {data_byte, 24'd0}
                     : (blk[pos[5:2]] | ({24'd0, data_byte} << (8 * (3 - pos[1:0]))));
    end else if (cmd.round) begin
      // roll window; the new word lands at the tail
      for (int i = 0; i < 15; i++) begin
        blk[i] <= blk[i + 1];
      end
      blk[15] <= s1 + blk[9] + s0 + blk[0];
    end else if (cmd.zero_block) begin
      for (int i = 0; i < 14; i++) begin
        blk[i] <= '0;
      end
      blk[14] <= bits[63:32];
      blk[15] <= bits[31:0];
    end else if (cmd.pad_fill) begin
      for (int i = 0; i < 16; i++) begin
        if (i > int'(pos[5:2]) && !(cmd.pad_len && i >= 14)) begin
          blk[i] <= '0;
        end
      end
      blk[pos[5:2]] <= ((pos[1:0] == 2'd0) ? 32'd0 : blk[pos[5:2]])
                     | (32'h80 << (8 * (3 - pos[1:0])));
      if (cmd.pad_len) begin
        blk[14] <= bits[63:32];
        blk[15] <= bits[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      for (int i = 0; i < 8; i++) begin
        wv[i] <= chain[i];
      end
    end else if (cmd.round) begin
      wv[0] <= t1 + t2;
      wv[1] <= wv[0];
      wv[2] <= wv[1];
      wv[3] <= wv[2];
      wv[4] <= wv[3] + t1;
      wv[5] <= wv[4];
      wv[6] <= wv[5];
      wv[7] <= wv[6];
    end else if (cmd.fold) begin
      // working vars follow the folded chain, ready for a second pad block
      for (int i = 0; i < 8; i++) begin
        wv[i] <= chain[i] + wv[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
      rnd        <= '0;
      for (int i = 0; i < 8; i++) begin
        chain[i] <= sha_pkg::initial_hash(3'(i));
      end
    end else begin
      if (cmd.take_byte) begin
        byte_count <= byte_count + 1'b1;
      end
      if (cmd.start) begin
        rnd <= '0;
      end else if (cmd.round) begin
        rnd <= rnd + 1'b1;
      end
      if (cmd.fold) begin
        for (int i = 0; i < 8; i++) begin
          chain[i] <= chain[i] + wv[i];
        end
      end else if (cmd.emit_shift) begin
        for (int i = 0; i < 7; i++) begin
          chain[i] <= chain[i + 1];
        end
        chain[7] <= chain[0];
      end else if (cmd.finish) begin
        for (int i = 0; i < 8; i++) begin
          chain[i] <= sha_pkg::initial_hash(3'(i));
        end
      end
      if (cmd.finish) begin
        byte_count <= '0;
      end
    end
  end

endmodule

@@ rtl/sha_ctrl.sv @@
// sha_ctrl: sequencer for byte intake, rounds, padding and digest output
// depends on sha_pkg
`timescale 1ns / 1ps
module sha_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                byte_present,
  input  logic                end_of_message,
  input  logic                out_stall,
  output logic                out_valid,
  output logic [2:0]          word_index,
  input  sha_pkg::dp_stat_t   stat,
  output sha_pkg::dp_cmd_t    cmd
);

  sha_pkg::state_t state, state_next;
  logic pending, pending_next;   // padding still to do after this block
  logic second, second_next;     // a second pad block follows
  logic [2:0] widx, widx_next;
  logic take;
  logic was_final;

  assign take       = in_valid && (state == sha_pkg::ST_IDLE);
  assign in_stall   = (state != sha_pkg::ST_IDLE);
  assign out_valid  = (state == sha_pkg::ST_EMIT);
  assign word_index = widx;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= sha_pkg::ST_IDLE;
      pending <= 1'b0;
      second  <= 1'b0;
      widx    <= '0;
    end else begin
      state   <= state_next;
      pending <= pending_next;
      second  <= second_next;
      widx    <= widx_next;
    end
  end

  always_comb begin
    state_next   = state;
    pending_next = pending;
    second_next  = second;
    widx_next    = widx;
    cmd          = '0;
    unique case (state)
      sha_pkg::ST_IDLE: begin
        if (take) begin
          cmd.take_byte = byte_present;
          pending_next  = end_of_message;
          if (byte_present && stat.block_full) begin
            cmd.start  = 1'b1;
            state_next = sha_pkg::ST_ROUND;
          end else if (end_of_message) begin
            state_next = sha_pkg::ST_PAD;
          end
        end
      end
      sha_pkg::ST_PAD: begin
        // count is final here, so the pad position is valid
        cmd.pad_fill = 1'b1;
        cmd.pad_len  = !stat.pad_two;
        second_next  = stat.pad_two;
        pending_next = 1'b0;
        cmd.start    = 1'b1;
        state_next   = sha_pkg::ST_ROUND;
      end
      sha_pkg::ST_ROUND: begin
        cmd.round = 1'b1;
        if (stat.last_round) begin
          state_next = sha_pkg::ST_FOLD;
        end
      end
      sha_pkg::ST_FOLD: begin
        cmd.fold = 1'b1;
        priority if (pending) begin
          state_next = sha_pkg::ST_PAD;
        end else if (second) begin
          cmd.zero_block = 1'b1;
          second_next    = 1'b0;
          state_next     = sha_pkg::ST_ROUND;
        end else if (widx == 3'd0 && was_final) begin
          widx_next  = '0;
          state_next = sha_pkg::ST_EMIT;
        end else begin
          state_next = sha_pkg::ST_IDLE;
        end
      end
      sha_pkg::ST_EMIT: begin
        if (!out_stall) begin
          cmd.emit_shift = (widx != 3'd7);
          widx_next      = widx + 1'b1;
          if (widx == 3'd7) begin
            cmd.finish = 1'b1;
            state_next = sha_pkg::ST_IDLE;
          end
        end
      end
      default: state_next = sha_pkg::ST_IDLE;
    endcase
  end

  // marks that the block now compressing ends a message
  always_ff @(posedge clk) begin
    if (rst) begin
      was_final <= 1'b0;
    end else if (state == sha_pkg::ST_PAD) begin
      was_final <= 1'b1;
    end else if (state == sha_pkg::ST_EMIT) begin
      was_final <= 1'b0;
    end
  end

  // zero block also restarts rounds from the folded chain
  // (working vars take the folded chain at the fold edge and the round count has wrapped)

`ifndef SYNTHESIS
  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    (state != sha_pkg::ST_IDLE) |-> !cmd.take_byte) else $error("byte taken while busy");
  a_emit_order: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && widx != 3'd7) |=> (out_valid && widx == $past(widx) + 3'd1))
    else $error("digest word order broken");
  a_round_only: assert property (@(posedge clk) disable iff (rst)
    cmd.round |-> (state == sha_pkg::ST_ROUND)) else $error("round outside round state");
`endif

endmodule
